// File: design/wmvs_pkg.sv
`default_nettype none
package wmvs_pkg;

	localparam int WINDOW = 16;
	localparam int SMP_W  = 16;
	localparam int CW     = $clog2(WINDOW + 1);
	localparam int PW     = $clog2(WINDOW);

	// sample minus mean, signed
	localparam int V_W    = SMP_W + 1;
	localparam int SUM_W  = SMP_W + CW;
	localparam int SQ_W   = 2 * SMP_W + CW;
	localparam int SXY_W  = V_W + 2 * CW;
	localparam int SY_W   = V_W + CW;
	localparam int SX_W   = 2 * CW;
	localparam int SXX_W  = 3 * CW;
	localparam int P_W    = V_W + 3 * CW + 1;
	localparam int NUM_W  = P_W + 1;
	localparam int N100_W = NUM_W + 8;
	localparam int DVS_W  = 4 * CW;
	localparam int SPD_W  = SQ_W + 1 + 4;
	localparam int DIV_W  = (N100_W > SPD_W) ? N100_W : SPD_W;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DVS_W-1:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [CW-1:0]    pos;
		logic [SMP_W-1:0] data;
	} win_rd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUMGO,
		S_SUM,
		S_MEAN0,
		S_MEAN,
		S_STATGO,
		S_STAT,
		S_NUM1,
		S_NUM2,
		S_NUM3,
		S_SPD0,
		S_SPD,
		S_SLP0,
		S_SLP,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

// File: design/wmvs_div.sv
`default_nettype none
module wmvs_div (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wmvs_pkg::div_cmd_t               cmd,
	output logic                             done,
	output logic [wmvs_pkg::DIV_W-1:0]       quo
);
	import wmvs_pkg::*;

	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  den_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				cnt_q <= DCNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			den_q <= cmd.den;
			quo_q <= cmd.num;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// File: design/wmvs_win.sv
`default_nettype none
module wmvs_win (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  wire  [wmvs_pkg::SMP_W-1:0]       wr_data,
	input  wire                              walk_start,
	output wmvs_pkg::win_rd_t                rd,
	output logic [wmvs_pkg::CW-1:0]          count
);
	import wmvs_pkg::*;

	logic [SMP_W-1:0] mem [WINDOW];
	logic [CW-1:0]    count_q;
	logic [PW-1:0]    oldest_q;
	logic             walking_q;
	logic [CW-1:0]    idx_q;
	logic [PW-1:0]    addr_q;
	logic             rvalid_q;
	logic             rlast_q;
	logic [CW-1:0]    rpos_q;
	logic [SMP_W-1:0] rdata_q;
	logic             full;
	logic [PW-1:0]    wr_addr;
	logic [CW-1:0]    idx_nx;

	assign full    = count_q == CW'(WINDOW);
	assign wr_addr = full ? oldest_q : count_q[PW-1:0];
	assign idx_nx  = idx_q + 1'b1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (walking_q)
			rdata_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			oldest_q  <= '0;
			walking_q <= 1'b0;
			idx_q     <= '0;
			addr_q    <= '0;
			rvalid_q  <= 1'b0;
			rlast_q   <= 1'b0;
			rpos_q    <= '0;
		end else begin
			if (wr_en) begin
				if (!full)
					count_q <= count_q + 1'b1;
				else
					oldest_q <= (oldest_q == PW'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
			end
			rvalid_q <= walking_q;
			rlast_q  <= walking_q && (idx_nx == count_q);
			rpos_q   <= idx_nx;
			// walk oldest to newest around the ring
			if (walk_start) begin
				walking_q <= 1'b1;
				idx_q     <= '0;
				addr_q    <= oldest_q;
			end else if (walking_q) begin
				idx_q  <= idx_nx;
				addr_q <= (addr_q == PW'(WINDOW - 1)) ? '0 : addr_q + 1'b1;
				if (idx_nx == count_q)
					walking_q <= 1'b0;
			end
		end
	end

	assign rd.valid = rvalid_q;
	assign rd.last  = rlast_q;
	assign rd.pos   = rpos_q;
	assign rd.data  = rdata_q;
	assign count    = count_q;

endmodule
`default_nettype wire

// File: design/window_mean_variance_slope.sv
// channel | signals                                   | direction
// input   | in_valid, in_ready, sample                | request in
// output  | out_valid, out_ready, mean, spread_q4,    | result out
//         | slope_x100, held_count                    |
// A shared divider, used three times per request, resolves one quotient bit per cycle.
// The window is walked twice through its single read port, one sample per cycle.
// Reset clears fill count, ring pointer and control; window contents stay undefined.
// A finished result waits in the output register while the next request is taken;
// a result that is not taken holds the last step until the output frees up.
`default_nettype none
module window_mean_variance_slope (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [15:0]                  sample,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [15:0]                  mean,
	output logic [31:0]                  spread_q4,
	output logic signed [31:0]           slope_x100,
	output logic [4:0]                   held_count
);
	import wmvs_pkg::*;

	state_t state_q, state_nx;

	win_rd_t          rd;
	logic [CW-1:0]    n;
	div_cmd_t         dcmd;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic             accept;
	logic             short;

	logic [SUM_W-1:0]         sum_q;
	logic [SMP_W-1:0]         mean_q;
	logic                     valid_s1, last_s1, valid_s2, last_s2;
	logic [CW-1:0]            pos_s1, pos_s2;
	logic signed [V_W-1:0]    v_s1, v_s2;
	logic [2*SMP_W-1:0]       sq_s2;
	logic signed [V_W+CW:0]   pv_s2;
	logic [2*CW-1:0]          pp_s2;
	logic signed [2*V_W-1:0]  sq_full;
	logic signed [V_W+CW:0]   pv_full;
	logic [SQ_W-1:0]          sq_acc_q;
	logic signed [SXY_W-1:0]  sxy_q;
	logic signed [SY_W-1:0]   sy_q;
	logic [SX_W-1:0]          sx_q;
	logic [SXX_W-1:0]         sxx_q;
	logic signed [P_W-1:0]    p1_q, p2_q;
	logic [DVS_W-1:0]         p3_q, p4_q, den_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [N100_W-1:0] n100;
	logic [N100_W-1:0]        mag_c;
	logic [DIV_W-1:0]         mag_q;
	logic                     neg_q;
	logic [SQ_W:0]            dsum;
	logic [31:0]              spread_r_q;
	logic [31:0]              slope_r_q;
	logic [DIV_W-1:0]         lim;

	logic        out_valid_q;
	logic [15:0] mean_o_q;
	logic [31:0] spread_o_q;
	logic [31:0] slope_o_q;
	logic [4:0]  cnt_o_q;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign short    = n < CW'(3);
	assign lim      = DIV_W'(33'h0_8000_0000);

	wmvs_win u_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept),
		.wr_data    (sample),
		.walk_start (state_q == S_SUMGO || state_q == S_STATGO),
		.rd         (rd),
		.count      (n)
	);

	wmvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign dsum = {1'b0, sq_acc_q} + (SQ_W+1)'({n, 1'b0});

	always_comb begin
		dcmd.start = 1'b0;
		dcmd.num   = '0;
		dcmd.den   = '0;
		unique case (state_q)
			S_MEAN0: begin
				dcmd.start = 1'b1;
				dcmd.num   = DIV_W'(sum_q + SUM_W'(n >> 1));
				dcmd.den   = DVS_W'(n);
			end
			S_SPD0: begin
				dcmd.start = 1'b1;
				dcmd.num   = DIV_W'({dsum, 4'b0000});
				dcmd.den   = DVS_W'(n);
			end
			S_SLP0: begin
				dcmd.start = 1'b1;
				dcmd.num   = mag_q;
				dcmd.den   = den_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_nx = S_SUMGO;
			S_SUMGO:  state_nx = S_SUM;
			S_SUM:    if (rd.valid && rd.last) state_nx = S_MEAN0;
			S_MEAN0:  state_nx = S_MEAN;
			S_MEAN:   if (div_done) state_nx = S_STATGO;
			S_STATGO: state_nx = S_STAT;
			S_STAT:   if (valid_s2 && last_s2) state_nx = S_NUM1;
			S_NUM1:   state_nx = S_NUM2;
			S_NUM2:   state_nx = S_NUM3;
			S_NUM3:   state_nx = S_SPD0;
			S_SPD0:   state_nx = S_SPD;
			S_SPD:    if (div_done) state_nx = S_SLP0;
			S_SLP0:   state_nx = S_SLP;
			S_SLP:    if (div_done) state_nx = S_FIN;
			S_FIN:    if (!out_valid_q) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// deviation pipeline: read -> subtract -> multiply -> accumulate
	assign sq_full = v_s1 * v_s1;
	assign pv_full = $signed({1'b0, pos_s1}) * v_s1;
	assign n100    = (N100_W)'(num_q) * $signed(9'sd100);
	assign mag_c   = n100[N100_W-1] ? N100_W'(-n100) : N100_W'(n100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= rd.valid && state_q == S_STAT;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SUMGO)
			sum_q <= '0;
		else if (state_q == S_SUM && rd.valid)
			sum_q <= sum_q + SUM_W'(rd.data);
		if (state_q == S_MEAN && div_done)
			mean_q <= div_quo[SMP_W-1:0];

		last_s1 <= rd.last;
		pos_s1  <= rd.pos;
		v_s1    <= $signed({1'b0, rd.data}) - $signed({1'b0, mean_q});
		last_s2 <= last_s1;
		pos_s2  <= pos_s1;
		v_s2    <= v_s1;
		sq_s2   <= sq_full[2*SMP_W-1:0];
		pv_s2   <= pv_full;
		pp_s2   <= pos_s1 * pos_s1;

		if (state_q == S_STATGO) begin
			sq_acc_q <= '0;
			sxy_q    <= '0;
			sy_q     <= '0;
			sx_q     <= '0;
			sxx_q    <= '0;
		end else if (valid_s2) begin
			sq_acc_q <= sq_acc_q + SQ_W'(sq_s2);
			sxy_q    <= sxy_q + SXY_W'(pv_s2);
			sy_q     <= sy_q + SY_W'(v_s2);
			sx_q     <= sx_q + SX_W'(pos_s2);
			sxx_q    <= sxx_q + SXX_W'(pp_s2);
		end

		if (state_q == S_NUM1) begin
			p1_q <= $signed({1'b0, n}) * sxy_q;
			p2_q <= $signed({1'b0, sx_q}) * sy_q;
			p3_q <= n * sxx_q;
			p4_q <= sx_q * sx_q;
		end
		if (state_q == S_NUM2) begin
			num_q <= NUM_W'(p1_q) - NUM_W'(p2_q);
			den_q <= p3_q - p4_q;
		end
		if (state_q == S_NUM3) begin
			neg_q <= n100[N100_W-1];
			mag_q <= DIV_W'(mag_c);
		end

		// saturate the dispersion
		if (state_q == S_SPD && div_done)
			spread_r_q <= (div_quo > DIV_W'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : div_quo[31:0];
		// clamp the slope to the signed range
		if (state_q == S_SLP && div_done) begin
			if (neg_q)
				slope_r_q <= (div_quo > lim) ? 32'h8000_0000 : 32'h0 - div_quo[31:0];
			else
				slope_r_q <= (div_quo >= lim) ? 32'h7FFF_FFFF : div_quo[31:0];
		end

		if (state_q == S_FIN && !out_valid_q) begin
			mean_o_q   <= mean_q;
			spread_o_q <= short ? 32'd16000 : spread_r_q;
			slope_o_q  <= short ? 32'd0 : slope_r_q;
			cnt_o_q    <= 5'(n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_FIN && !out_valid_q)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid  = out_valid_q;
	assign mean       = mean_o_q;
	assign spread_q4  = spread_o_q;
	assign slope_x100 = $signed(slope_o_q);
	assign held_count = cnt_o_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SUMGO)
		else $error("accepted request did not start the window walk");

	a_div_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_MEAN || state_q == S_SPD || state_q == S_SLP))
		else $error("divider finished outside a wait state");

	a_pipe_in_stat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> state_q == S_STAT)
		else $error("deviation pipeline active outside the statistics walk");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n <= CW'(WINDOW))
		else $error("fill count beyond window depth");

endmodule
`default_nettype wire
